// ----- src/diec_pkg.sv -----
// Shared types, register map codes and reset values of the DSP interrupt event controller.
package diec_pkg;

    localparam int NUM_EVENTS_DEF = 128;
    localparam int NUM_CPU_INTS   = 16;

    localparam logic [1:0] MODE_RAISE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [5:0] REG_FLAG_LO   = 6'd0;
    localparam logic [5:0] REG_FLAG_HI   = 6'd3;
    localparam logic [5:0] REG_SET_LO    = 6'd4;
    localparam logic [5:0] REG_SET_HI    = 6'd7;
    localparam logic [5:0] REG_CLR_LO    = 6'd8;
    localparam logic [5:0] REG_CLR_HI    = 6'd11;
    localparam logic [5:0] REG_MASK_LO   = 6'd12;
    localparam logic [5:0] REG_MASK_HI   = 6'd15;
    localparam logic [5:0] REG_MFLAG_LO  = 6'd16;
    localparam logic [5:0] REG_MFLAG_HI  = 6'd19;
    localparam logic [5:0] REG_XMASK_LO  = 6'd20;
    localparam logic [5:0] REG_XMASK_HI  = 6'd23;
    localparam logic [5:0] REG_MXFLAG_LO = 6'd24;
    localparam logic [5:0] REG_MXFLAG_HI = 6'd27;
    localparam logic [5:0] REG_MUX_LO    = 6'd28;
    localparam logic [5:0] REG_MUX_HI    = 6'd30;
    localparam logic [5:0] REG_AEG_LO    = 6'd31;
    localparam logic [5:0] REG_AEG_HI    = 6'd32;
    localparam logic [5:0] REG_STATUS    = 6'd33;
    localparam logic [5:0] REG_STATCLR   = 6'd34;
    localparam logic [5:0] REG_DROP      = 6'd35;

    localparam logic [4:0]  NO_ROUTE   = 5'd16;
    localparam logic [15:0] EXC_LINES  = 16'h0002;
    localparam logic [6:0]  FIRST_EVT  = 7'd4;

    localparam logic [31:0] MASK0_RST  = 32'h0000_000f;
    localparam logic [31:0] XMASK_RST  = 32'hffff_ffff;
    localparam logic [31:0] MUX0_RST   = 32'h0706_0504;
    localparam logic [31:0] MUX1_RST   = 32'h0b0a_0908;
    localparam logic [31:0] MUX2_RST   = 32'h0f0e_0d0c;
    localparam logic [31:0] AEG0_RST   = 32'h0302_0100;
    localparam logic [31:0] AEG1_RST   = 32'h0706_0504;

    // Request to rewrite the select table from one mux word.
    typedef struct packed {
        logic        valid;
        logic [1:0]  which;
        logic [31:0] word;
    } t_tbl_load;

    // Power-on content of a select table entry: events 4..15 route to themselves.
    function automatic logic [4:0] tbl_reset_val(input logic [6:0] ev);
        logic [4:0] val;
        if (ev >= 7'd4 && ev <= 7'd15) begin
            val = ev[4:0];
        end else begin
            val = NO_ROUTE;
        end
        return val;
    endfunction

endpackage

// ----- src/diec_ram.sv -----
// Generic simple dual-read RAM with one write port and registered reads.
module diec_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- src/diec_sel_table.sv -----
// Event to CPU interrupt select table with power-on defaults and a four-step mux word loader.
module diec_sel_table #(
    parameter int NUM_EVENTS = diec_pkg::NUM_EVENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_re,
    input  logic [$clog2(NUM_EVENTS)-1:0] i_addr_a,
    input  logic [$clog2(NUM_EVENTS)-1:0] i_addr_b,
    input  diec_pkg::t_tbl_load           i_load,
    output logic [4:0]                    o_ent_a,
    output logic [4:0]                    o_ent_b,
    output logic                          o_busy
);

    localparam int AW = $clog2(NUM_EVENTS);

    logic                  r_busy;
    logic [1:0]            r_cnt;
    logic [1:0]            r_which;
    logic [31:0]           r_word;
    logic [NUM_EVENTS-1:0] r_tbl_vld;
    logic                  r_vld_a;
    logic                  r_vld_b;
    logic [AW-1:0]         r_addr_a;
    logic [AW-1:0]         r_addr_b;

    logic [6:0]    sweep_ev;
    logic          sweep_we;
    logic [AW-1:0] sweep_addr;
    logic [4:0]    sweep_data;
    logic [4:0]    ram_a;
    logic [4:0]    ram_b;

    // Each byte of the mux word names an event; it takes interrupt (which + 1) * 4 + byte.
    assign sweep_ev   = r_word[{r_cnt, 3'b000} +: 7];
    assign sweep_we   = r_busy && ({1'b0, sweep_ev} < 8'(NUM_EVENTS));
    assign sweep_addr = sweep_ev[AW-1:0];
    assign sweep_data = {1'b0, r_which + 2'd1, r_cnt};

    diec_ram #(
        .WIDTH (5),
        .DEPTH (NUM_EVENTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (sweep_we),
        .i_waddr   (sweep_addr),
        .i_wdata   (sweep_data),
        .i_re      (i_re),
        .i_raddr_a (i_addr_a),
        .i_raddr_b (i_addr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= 2'd0;
            r_tbl_vld <= '0;
        end else begin
            if (i_load.valid) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
            if (sweep_we) begin
                r_tbl_vld[sweep_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_which <= i_load.which;
            r_word  <= i_load.word;
        end
        if (i_re) begin
            r_vld_a  <= r_tbl_vld[i_addr_a];
            r_vld_b  <= r_tbl_vld[i_addr_b];
            r_addr_a <= i_addr_a;
            r_addr_b <= i_addr_b;
        end
    end

    // An entry never loaded since reset reads as its power-on value.
    assign o_ent_a = r_vld_a ? ram_a : diec_pkg::tbl_reset_val(7'(r_addr_a));
    assign o_ent_b = r_vld_b ? ram_b : diec_pkg::tbl_reset_val(7'(r_addr_b));
    assign o_busy  = r_busy;

endmodule

// ----- src/dsp_interrupt_event_controller.sv -----
// Top level of the DSP interrupt event controller: request register, event logic, result register.
// An accepted request is held in the request register and its result in the result register;
// one request is taken per cycle while the result side keeps pace and no mux write is in progress.
// A write to one of the three mux registers blocks new requests while the select table port
// loads four entries, one per cycle.
// Synchronous active-low reset restores the state registers to power-on values; the select
// table needs no clearing pass, as per-entry valid bits make unloaded entries read as default.
module dsp_interrupt_event_controller #(
    parameter int NUM_EVENTS = diec_pkg::NUM_EVENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // mode[1:0], event_line[8:2], reg_index[14:9],
                                       // write_data[46:15], zero[47]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // read_data[31:0], irq_lines[47:32],
                                       // signal_sent[48], access_error[49], zero[55:50]
);

    localparam int EV_AW = $clog2(NUM_EVENTS);

    // Request register
    logic        r_in_vld;
    logic [1:0]  r_mode;
    logic [6:0]  r_line;
    logic [5:0]  r_idx;
    logic [31:0] r_data;

    // Result register
    logic        r_out_vld;
    logic [31:0] r_rd;
    logic [15:0] r_irq;
    logic        r_sent;
    logic        r_err;

    // Controller state
    logic [31:0] r_flags  [4];
    logic [31:0] r_mask   [4];
    logic [31:0] r_mflags [4];
    logic [31:0] r_xmask  [4];
    logic [31:0] r_mxflags[4];
    logic [31:0] r_mux    [3];
    logic [31:0] r_aeg    [2];
    logic [31:0] r_status;
    logic [31:0] r_sclr;
    logic [31:0] r_drop;

    logic [31:0] n_flags  [4];
    logic [31:0] n_mask   [4];
    logic [31:0] n_mflags [4];
    logic [31:0] n_xmask  [4];
    logic [31:0] n_mxflags[4];
    logic [31:0] n_mux    [3];
    logic [31:0] n_aeg    [2];
    logic [31:0] n_status;
    logic [31:0] n_sclr;
    logic [31:0] n_drop;
    logic [31:0] n_rd;
    logic [15:0] n_irq;
    logic        n_sent;
    logic        n_err;

    logic                 accept;
    logic                 advance;
    logic                 in_is_mux;
    logic                 tbl_busy;
    logic [4:0]           ent_a;
    logic [4:0]           ent_b;
    logic [EV_AW-1:0]     rd_addr_a;
    logic [EV_AW-1:0]     rd_addr_b;
    logic [6:0]           s_line;
    diec_pkg::t_tbl_load  tbl_load;

    assign in_is_mux = (r_mode == diec_pkg::MODE_WRITE) && (r_idx >= diec_pkg::REG_MUX_LO)
                       && (r_idx <= diec_pkg::REG_MUX_HI);
    assign advance   = r_in_vld && (!r_out_vld || m_axis_tready);
    // A mux write leaves alone so that no table read overlaps the load that follows it.
    assign s_axis_tready = !tbl_busy && (!r_in_vld || (advance && !in_is_mux));
    assign accept    = s_axis_tvalid && s_axis_tready;

    assign s_line    = s_axis_tdata[8:2];
    assign rd_addr_a = s_line[EV_AW-1:0];
    assign rd_addr_b = {{(EV_AW-2){1'b0}}, s_line[6:5]};

    assign tbl_load.valid = advance && in_is_mux;
    assign tbl_load.which = r_idx[1:0];
    assign tbl_load.word  = r_data;

    diec_sel_table #(
        .NUM_EVENTS (NUM_EVENTS)
    ) u_sel_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_re     (accept),
        .i_addr_a (rd_addr_a),
        .i_addr_b (rd_addr_b),
        .i_load   (tbl_load),
        .o_ent_a  (ent_a),
        .o_ent_b  (ent_b),
        .o_busy   (tbl_busy)
    );

    always_comb begin
        logic [1:0]  w;
        logic [4:0]  b;
        logic [31:0] bitv;
        logic [31:0] fl;
        logic [1:0]  k;
        logic [15:0] lines;

        n_flags   = r_flags;
        n_mask    = r_mask;
        n_mflags  = r_mflags;
        n_xmask   = r_xmask;
        n_mxflags = r_mxflags;
        n_mux     = r_mux;
        n_aeg     = r_aeg;
        n_status  = r_status;
        n_sclr    = r_sclr;
        n_drop    = r_drop;
        n_rd      = 32'd0;
        n_irq     = 16'd0;
        n_sent    = 1'b0;
        n_err     = 1'b0;

        w     = r_line[6:5];
        b     = r_line[4:0];
        bitv  = 32'd1 << b;
        fl    = r_flags[w] | bitv;
        k     = r_idx[1:0];
        lines = 16'd0;

        case (r_mode)
            diec_pkg::MODE_RAISE: begin
                if (r_line >= diec_pkg::FIRST_EVT && ({1'b0, r_line} < 8'(NUM_EVENTS))) begin
                    n_flags[w]  = fl;
                    n_mflags[w] = fl & ~r_mask[w];
                    n_sent      = 1'b1;
                    if (!r_xmask[w][b]) begin
                        n_mxflags[w] = fl & ~r_xmask[w];
                        n_irq        = diec_pkg::EXC_LINES;
                    end else begin
                        if (!ent_a[4]) begin
                            n_status = {1'b0, r_line, 4'd0, ent_a[3:0], 16'd0};
                            lines    = lines | (16'd1 << ent_a[3:0]);
                        end
                        // The combined event of the word is routed when the event is unmasked.
                        if (!r_mask[w][b] && !ent_b[4]) begin
                            n_status = {1'b0, 5'd0, w, 4'd0, ent_b[3:0], 16'd0};
                            lines    = lines | (16'd1 << ent_b[3:0]);
                        end
                        n_irq = lines;
                    end
                end
            end
            diec_pkg::MODE_READ: begin
                unique case (r_idx) inside
                    [diec_pkg::REG_FLAG_LO:diec_pkg::REG_FLAG_HI]:     n_rd = r_flags[k];
                    [diec_pkg::REG_MASK_LO:diec_pkg::REG_MASK_HI]:     n_rd = r_mask[k];
                    [diec_pkg::REG_MFLAG_LO:diec_pkg::REG_MFLAG_HI]:   n_rd = r_mflags[k];
                    [diec_pkg::REG_XMASK_LO:diec_pkg::REG_XMASK_HI]:   n_rd = r_xmask[k];
                    [diec_pkg::REG_MXFLAG_LO:diec_pkg::REG_MXFLAG_HI]: n_rd = r_mxflags[k];
                    [diec_pkg::REG_MUX_LO:diec_pkg::REG_MUX_HI]:       n_rd = r_mux[k];
                    [diec_pkg::REG_AEG_LO:diec_pkg::REG_AEG_HI]:       n_rd = r_aeg[~r_idx[0]];
                    diec_pkg::REG_STATUS:                              n_rd = r_status;
                    diec_pkg::REG_STATCLR:                             n_rd = r_sclr;
                    diec_pkg::REG_DROP:                                n_rd = r_drop;
                    default:                                           n_err = 1'b1;
                endcase
            end
            diec_pkg::MODE_WRITE: begin
                unique case (r_idx) inside
                    [diec_pkg::REG_SET_LO:diec_pkg::REG_SET_HI]: begin
                        n_flags[k] = r_flags[k] | r_data;
                    end
                    [diec_pkg::REG_CLR_LO:diec_pkg::REG_CLR_HI]: begin
                        n_flags[k]   = r_flags[k] & ~r_data;
                        n_mflags[k]  = r_mflags[k] & ~r_data;
                        n_mxflags[k] = r_mxflags[k] & ~r_data;
                        n_status     = 32'd0;
                    end
                    [diec_pkg::REG_MASK_LO:diec_pkg::REG_MASK_HI]: begin
                        n_mask[k] = r_data;
                    end
                    [diec_pkg::REG_XMASK_LO:diec_pkg::REG_XMASK_HI]: begin
                        n_xmask[k] = r_data;
                    end
                    [diec_pkg::REG_MUX_LO:diec_pkg::REG_MUX_HI]: begin
                        n_mux[k] = r_data;
                    end
                    [diec_pkg::REG_AEG_LO:diec_pkg::REG_AEG_HI]: begin
                        n_aeg[~r_idx[0]] = r_data;
                    end
                    diec_pkg::REG_STATUS: begin
                        n_status = r_data;
                    end
                    diec_pkg::REG_STATCLR: begin
                        n_sclr = r_data;
                        if (r_data[0]) begin
                            n_status      = 32'd0;
                            n_flags[3][0] = 1'b0;
                        end
                    end
                    diec_pkg::REG_DROP: begin
                        n_drop = r_data;
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_flags[i]   <= 32'd0;
                r_mask[i]    <= 32'd0;
                r_mflags[i]  <= 32'd0;
                r_xmask[i]   <= diec_pkg::XMASK_RST;
                r_mxflags[i] <= 32'd0;
            end
            r_mask[0] <= diec_pkg::MASK0_RST;
            r_mux[0]  <= diec_pkg::MUX0_RST;
            r_mux[1]  <= diec_pkg::MUX1_RST;
            r_mux[2]  <= diec_pkg::MUX2_RST;
            r_aeg[0]  <= diec_pkg::AEG0_RST;
            r_aeg[1]  <= diec_pkg::AEG1_RST;
            r_status  <= 32'd0;
            r_sclr    <= 32'd0;
            r_drop    <= 32'd0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_flags   <= n_flags;
                r_mask    <= n_mask;
                r_mflags  <= n_mflags;
                r_xmask   <= n_xmask;
                r_mxflags <= n_mxflags;
                r_mux     <= n_mux;
                r_aeg     <= n_aeg;
                r_status  <= n_status;
                r_sclr    <= n_sclr;
                r_drop    <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= s_axis_tdata[1:0];
            r_line <= s_axis_tdata[8:2];
            r_idx  <= s_axis_tdata[14:9];
            r_data <= s_axis_tdata[46:15];
        end
        if (advance) begin
            r_rd   <= n_rd;
            r_irq  <= n_irq;
            r_sent <= n_sent;
            r_err  <= n_err;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_err, r_sent, r_irq, r_rd};

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the DSP interrupt event controller: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASE_ITEMS = 190;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  line;
        logic [5:0]  idx;
        logic [31:0] data;
    } t_req;

    typedef struct packed {
        logic [31:0] rd;
        logic [15:0] irq;
        logic        sig;
        logic        err;
    } t_resp;

    typedef struct packed {
        t_req  rq;
        logic  chk;
        t_resp rs;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    // Shadow copy of the controller's register file and select table.
    logic [31:0] flag_w   [4];
    logic [31:0] set_w    [4];
    logic [31:0] clr_w    [4];
    logic [31:0] mask_w   [4];
    logic [31:0] mflag_w  [4];
    logic [31:0] xmask_w  [4];
    logic [31:0] mxflag_w [4];
    logic [31:0] mux_w    [3];
    logic [31:0] aeg_w    [2];
    logic [31:0] status_r;
    logic [31:0] statclr_r;
    logic [31:0] drop_r;
    logic [4:0]  route_tbl [128];

    t_resp outstanding_resp[$];
    t_row  dir_rows[$];
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    bit    hold_off_go = 1'b0;
    bit    hold_done = 1'b0;
    int    hold_left = 0;

    dsp_interrupt_event_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    function automatic void shadow_reset();
        for (int i = 0; i < 4; i++) begin
            flag_w[i]   = '0;
            set_w[i]    = '0;
            clr_w[i]    = '0;
            mask_w[i]   = '0;
            mflag_w[i]  = '0;
            xmask_w[i]  = diec_pkg::XMASK_RST;
            mxflag_w[i] = '0;
        end
        mask_w[0] = diec_pkg::MASK0_RST;
        mux_w[0]  = diec_pkg::MUX0_RST;
        mux_w[1]  = diec_pkg::MUX1_RST;
        mux_w[2]  = diec_pkg::MUX2_RST;
        aeg_w[0]  = diec_pkg::AEG0_RST;
        aeg_w[1]  = diec_pkg::AEG1_RST;
        status_r  = '0;
        statclr_r = '0;
        drop_r    = '0;
        for (int i = 0; i < 128; i++) begin
            route_tbl[i] = (i >= 4 && i <= 15) ? 5'(i) : diec_pkg::NO_ROUTE;
        end
    endfunction

    // One routing step: a routed event also records itself in the status word.
    function automatic logic [15:0] route_to_cpu(input logic [6:0] ev);
        logic [4:0] n;
        n = route_tbl[ev];
        if (n < diec_pkg::NUM_CPU_INTS) begin
            status_r = {1'b0, ev, 3'b000, n, 16'h0000};
            return 16'd1 << n;
        end
        return 16'd0;
    endfunction

    // Applies one request to the shadow state and gives the response it causes.
    // The register blocks up to the mux block start on multiples of four, so idx[1:0] is their word offset.
    function automatic t_resp controller_step(input t_req rq);
        t_resp       rs;
        logic [1:0]  w;
        logic [1:0]  k;
        logic [31:0] bitm;
        logic [31:0] v;
        logic [15:0] lines;
        rs = '0;
        k  = rq.idx[1:0];
        v  = rq.data;
        if (rq.mode == diec_pkg::MODE_RAISE) begin
            if (rq.line >= diec_pkg::FIRST_EVT) begin
                w    = rq.line[6:5];
                bitm = 32'd1 << rq.line[4:0];
                flag_w[w]  |= bitm;
                mflag_w[w]  = flag_w[w] & ~mask_w[w];
                rs.sig = 1'b1;
                if ((xmask_w[w] & bitm) == 0) begin
                    mxflag_w[w] = flag_w[w] & ~xmask_w[w];
                    rs.irq = diec_pkg::EXC_LINES;
                end else begin
                    lines = route_to_cpu(rq.line);
                    if ((mask_w[w] & bitm) == 0) begin
                        lines |= route_to_cpu({5'd0, w});
                    end
                    rs.irq = lines;
                end
            end
        end else if (rq.mode == diec_pkg::MODE_READ) begin
            if (rq.idx <= diec_pkg::REG_FLAG_HI) begin
                rs.rd = flag_w[k];
            end else if (rq.idx >= diec_pkg::REG_MASK_LO && rq.idx <= diec_pkg::REG_MASK_HI) begin
                rs.rd = mask_w[k];
            end else if (rq.idx >= diec_pkg::REG_MFLAG_LO
                         && rq.idx <= diec_pkg::REG_MFLAG_HI) begin
                rs.rd = mflag_w[k];
            end else if (rq.idx >= diec_pkg::REG_XMASK_LO
                         && rq.idx <= diec_pkg::REG_XMASK_HI) begin
                rs.rd = xmask_w[k];
            end else if (rq.idx >= diec_pkg::REG_MXFLAG_LO
                         && rq.idx <= diec_pkg::REG_MXFLAG_HI) begin
                rs.rd = mxflag_w[k];
            end else if (rq.idx >= diec_pkg::REG_MUX_LO && rq.idx <= diec_pkg::REG_MUX_HI) begin
                rs.rd = mux_w[k];
            end else if (rq.idx == diec_pkg::REG_AEG_LO || rq.idx == diec_pkg::REG_AEG_HI) begin
                rs.rd = aeg_w[rq.idx == diec_pkg::REG_AEG_HI];
            end else if (rq.idx == diec_pkg::REG_STATUS) begin
                rs.rd = status_r;
            end else if (rq.idx == diec_pkg::REG_STATCLR) begin
                rs.rd = statclr_r;
            end else if (rq.idx == diec_pkg::REG_DROP) begin
                rs.rd = drop_r;
            end else begin
                rs.err = 1'b1;
            end
        end else if (rq.mode == diec_pkg::MODE_WRITE) begin
            if (rq.idx >= diec_pkg::REG_SET_LO && rq.idx <= diec_pkg::REG_SET_HI) begin
                set_w[k]   = v;
                flag_w[k] |= v;
            end else if (rq.idx >= diec_pkg::REG_CLR_LO && rq.idx <= diec_pkg::REG_CLR_HI) begin
                clr_w[k]     = v;
                flag_w[k]   &= ~v;
                mflag_w[k]  &= ~v;
                mxflag_w[k] &= ~v;
                status_r     = '0;
            end else if (rq.idx >= diec_pkg::REG_MASK_LO && rq.idx <= diec_pkg::REG_MASK_HI) begin
                mask_w[k] = v;
            end else if (rq.idx >= diec_pkg::REG_XMASK_LO
                         && rq.idx <= diec_pkg::REG_XMASK_HI) begin
                xmask_w[k] = v;
            end else if (rq.idx >= diec_pkg::REG_MUX_LO && rq.idx <= diec_pkg::REG_MUX_HI) begin
                mux_w[k] = v;
                for (int i = 0; i < 4; i++) begin
                    route_tbl[v[8*i +: 7]] = 5'((int'(k) + 1) * 4 + i);
                end
            end else if (rq.idx == diec_pkg::REG_AEG_LO || rq.idx == diec_pkg::REG_AEG_HI) begin
                aeg_w[rq.idx == diec_pkg::REG_AEG_HI] = v;
            end else if (rq.idx == diec_pkg::REG_STATUS) begin
                status_r = v;
            end else if (rq.idx == diec_pkg::REG_STATCLR) begin
                statclr_r = v;
                if (v[0]) begin
                    status_r     = '0;
                    flag_w[3][0] = 1'b0;
                end
            end else if (rq.idx == diec_pkg::REG_DROP) begin
                drop_r = v;
            end else begin
                rs.err = 1'b1;
            end
        end
        return rs;
    endfunction

    // Mostly event raises and register traffic that steer the routing and exception paths.
    function automatic t_req random_request();
        t_req rq;
        int   sel;
        rq.mode = diec_pkg::MODE_RAISE;
        rq.line = 7'($urandom_range(127));
        rq.idx  = 6'($urandom_range(63));
        rq.data = $urandom;
        sel = $urandom_range(99);
        if (sel < 50) begin
            rq.line = ($urandom_range(9) == 0) ? 7'($urandom_range(3)) : 7'($urandom_range(127, 4));
        end else if (sel < 97) begin
            rq.mode = (sel < 72) ? diec_pkg::MODE_READ : diec_pkg::MODE_WRITE;
            rq.idx  = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 36))
                                               : 6'($urandom_range(35));
            if (rq.idx >= diec_pkg::REG_XMASK_LO && rq.idx <= diec_pkg::REG_XMASK_HI
                && $urandom_range(3) != 0) begin
                rq.data = ~(32'd1 << $urandom_range(31));
            end else if (rq.idx >= diec_pkg::REG_MUX_LO && rq.idx <= diec_pkg::REG_MUX_HI) begin
                // Bias some bytes towards the combined events so that they get a route.
                for (int i = 0; i < 4; i++) begin
                    rq.data[8*i +: 7] = ($urandom_range(3) == 0) ? 7'($urandom_range(3))
                                                                 : 7'($urandom_range(127));
                end
            end else if (rq.idx >= diec_pkg::REG_CLR_LO && rq.idx <= diec_pkg::REG_CLR_HI
                         && $urandom_range(1)) begin
                rq.data = 32'd1 << $urandom_range(31);
            end else if ($urandom_range(15) == 0) begin
                rq.data = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
            end
        end else begin
            rq.mode = MODE_UNUSED;
        end
        return rq;
    endfunction

    task automatic send_request(input t_req rq, input logic chk, input t_resp typed);
        t_resp pr;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, rq.data, rq.idx, rq.line, rq.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        pr = controller_step(rq);
        outstanding_resp.push_back(chk ? typed : pr);
    endtask

    task automatic add_row(input logic [1:0] m, input logic [6:0] ln, input logic [5:0] ix,
                           input logic [31:0] d, input logic chk = 1'b0,
                           input logic [31:0] rd = '0, input logic [15:0] irq = '0,
                           input logic sig = 1'b0, input logic err = 1'b0);
        t_row r;
        r.rq = '{mode: m, line: ln, idx: ix, data: d};
        r.chk = chk;
        r.rs = '{rd: rd, irq: irq, sig: sig, err: err};
        dir_rows.push_back(r);
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_resp got;
        t_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{rd: m_axis_tdata[31:0], irq: m_axis_tdata[47:32],
                    sig: m_axis_tdata[48], err: m_axis_tdata[49]};
            if (outstanding_resp.size() == 0) begin
                report_mismatch("response with no request outstanding", got.rd, '0);
            end else begin
                want = outstanding_resp.pop_front();
                if (got.rd !== want.rd) report_mismatch("read_data", got.rd, want.rd);
                if (got.irq !== want.irq) begin
                    report_mismatch("irq_lines", 32'(got.irq), 32'(want.irq));
                end
                if (got.sig !== want.sig) begin
                    report_mismatch("signal_sent", 32'(got.sig), 32'(want.sig));
                end
                if (got.err !== want.err) begin
                    report_mismatch("access_error", 32'(got.err), 32'(want.err));
                end
            end
        end
    end

    initial begin
        shadow_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_FLAG_LO, 32'h0, 1'b1, 32'h0);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_MASK_LO, 32'h0, 1'b1,
                diec_pkg::MASK0_RST);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_XMASK_HI, 32'h0, 1'b1,
                diec_pkg::XMASK_RST);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_MUX_LO, 32'h0, 1'b1,
                diec_pkg::MUX0_RST);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_AEG_LO, 32'h0, 1'b1,
                diec_pkg::AEG0_RST);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_SET_LO, 32'h0, 1'b1,
                32'h0, 16'h0, 1'b0, 1'b1);
        add_row(diec_pkg::MODE_READ, 7'd127, 6'd63, 32'h0, 1'b1, 32'h0, 16'h0, 1'b0, 1'b1);
        add_row(diec_pkg::MODE_WRITE, 7'd0, diec_pkg::REG_FLAG_LO, 32'hffff_ffff, 1'b1,
                32'h0, 16'h0, 1'b0, 1'b1);
        add_row(diec_pkg::MODE_WRITE, 7'd0, 6'd63, 32'hffff_ffff, 1'b1,
                32'h0, 16'h0, 1'b0, 1'b1);
        add_row(diec_pkg::MODE_RAISE, 7'd0, diec_pkg::REG_FLAG_LO, 32'h0, 1'b1);
        add_row(diec_pkg::MODE_RAISE, 7'd3, diec_pkg::REG_FLAG_LO, 32'h0, 1'b1);
        add_row(diec_pkg::MODE_RAISE, 7'd4, 6'd0, 32'h0);
        add_row(diec_pkg::MODE_RAISE, 7'd127, 6'd63, 32'hffff_ffff);
        add_row(MODE_UNUSED, 7'd127, 6'd63, 32'hffff_ffff, 1'b1);
        // Route the combined events 0..3; the top bit of a byte is not part of the event.
        add_row(diec_pkg::MODE_WRITE, 7'd0, diec_pkg::REG_MUX_LO, 32'h8302_0100);
        add_row(diec_pkg::MODE_RAISE, 7'd37, 6'd0, 32'h0);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_STATUS, 32'h0);
        // An event whose exception mask bit is clear takes the exception line only.
        add_row(diec_pkg::MODE_WRITE, 7'd0, diec_pkg::REG_XMASK_LO + 6'd1, 32'hffff_fffe);
        add_row(diec_pkg::MODE_RAISE, 7'd32, 6'd0, 32'h0, 1'b1, 32'h0,
                diec_pkg::EXC_LINES, 1'b1);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_MXFLAG_LO + 6'd1, 32'h0);
        add_row(diec_pkg::MODE_WRITE, 7'd0, diec_pkg::REG_SET_HI, 32'hffff_ffff);
        add_row(diec_pkg::MODE_WRITE, 7'd0, diec_pkg::REG_STATCLR, 32'h0000_0001);
        add_row(diec_pkg::MODE_WRITE, 7'd0, diec_pkg::REG_CLR_LO + 6'd1, 32'hffff_ffff);
        add_row(diec_pkg::MODE_WRITE, 7'd0, diec_pkg::REG_DROP, 32'hffff_ffff);
        add_row(diec_pkg::MODE_READ, 7'd0, diec_pkg::REG_FLAG_HI, 32'h0);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].rq, dir_rows[i].chk, dir_rows[i].rs);
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    // Long receiver hold-off while requests keep coming, so the block backs up.
                    hold_off_go   = 1'b1;
                end
                1: begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default: begin
                    send_idle_pct = 31;
                    stall_pct     = 31;
                end
            endcase
            repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;

        while (outstanding_resp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && outstanding_resp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
